### hw/rtl/kmd_pkg.sv
// Package for the k-way merge with duplicate-key removal.
// Holds the word types, controller states and the command/status bundles.
// No dependencies.
package kmd_pkg;

    localparam int KEY_W   = 64;
    localparam int STAMP_W = 32;
    localparam int RUN_W   = 3;
    localparam int RUNS_W  = 4;
    localparam int MAX_RUNS = 8;

    localparam logic [RUNS_W-1:0] RUNS_RESET = 4'd8;

    // Item operation codes
    localparam logic OP_NEXT    = 1'b0;
    localparam logic OP_EXHAUST = 1'b1;

    typedef struct packed {
        logic                      operation;
        logic [RUN_W-1:0]          run_index;
        logic signed [KEY_W-1:0]   record_key;
        logic [STAMP_W-1:0]        record_stamp;
    } t_item;

    typedef struct packed {
        logic                      emit_valid;
        logic signed [KEY_W-1:0]   out_key;
        logic [STAMP_W-1:0]        out_stamp;
        logic [RUN_W-1:0]          refill_run;
        logic                      priming;
        logic                      merge_done;
        logic                      run_error;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } t_status;

endpackage

### hw/rtl/kmd_ctrl.sv
// Controller state machine for the merge: idle, head scan, finish.
// Depends on kmd_pkg.
module kmd_ctrl
    import kmd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy
);

    t_state r_state;
    t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start && i_status.need_scan) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = start;
                busy         = 1'b0;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

### hw/rtl/kmd_datapath.sv
// Datapath for the merge: run heads, run count register, scan comparator,
// duplicate-key filter and result register. Depends on kmd_pkg.
module kmd_datapath
    import kmd_pkg::*;
#(
    parameter int NUM_RUNS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [RUNS_W-1:0] i_cfg_data,
    input  t_item             i_item,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic              o_strobe,
    output t_result           o_result
);

    localparam int HEADS = (NUM_RUNS < MAX_RUNS) ? NUM_RUNS : MAX_RUNS;
    localparam int IDX_W = $clog2(HEADS);
    localparam logic [RUNS_W-1:0] CAP = RUNS_W'(HEADS);

    // Run heads and merge state
    logic signed [KEY_W-1:0] r_head_key   [HEADS];
    logic [STAMP_W-1:0]      r_head_stamp [HEADS];
    logic [HEADS-1:0]        r_head_full;
    logic [RUNS_W-1:0]       r_runs;
    logic [RUNS_W-1:0]       r_primed;
    logic [RUN_W-1:0]        r_awaited;
    logic signed [KEY_W-1:0] r_last_key;
    logic                    r_last_set;

    // Scan state
    logic [RUN_W-1:0]        r_scan;
    logic                    r_found;
    logic [RUN_W-1:0]        r_best;
    logic signed [KEY_W-1:0] r_best_key;
    logic [STAMP_W-1:0]      r_best_stamp;

    logic                    r_strobe;
    t_result                 r_result;
    logic                    n_strobe;
    t_result                 n_result;

    logic [RUNS_W-1:0]       eff_runs;
    logic                    was_priming;
    logic                    run_match;
    logic [RUNS_W-1:0]       primed_inc;
    logic                    prime_more;
    logic                    aw_ok;
    logic [IDX_W-1:0]        aw_idx;
    logic [IDX_W-1:0]        scan_idx;
    logic [IDX_W-1:0]        best_idx;
    logic signed [KEY_W-1:0] scan_key;
    logic [STAMP_W-1:0]      scan_stamp;
    logic                    sorts_first;
    logic                    take;
    logic                    dup;

    // Clamp the run count to 1..CAP
    always_comb begin
        if (r_runs == '0) begin
            eff_runs = RUNS_W'(1);
        end else if (r_runs > CAP) begin
            eff_runs = CAP;
        end else begin
            eff_runs = r_runs;
        end
    end

    // Decode the offered word
    assign was_priming = r_primed < eff_runs;
    assign run_match   = i_item.run_index == r_awaited;
    assign primed_inc  = r_primed + RUNS_W'(1);
    assign prime_more  = primed_inc < eff_runs;
    assign aw_ok       = {1'b0, r_awaited} < CAP;
    assign aw_idx      = r_awaited[IDX_W-1:0];

    // Compare the scanned head against the best so far
    assign scan_idx    = r_scan[IDX_W-1:0];
    assign scan_key    = r_head_key[scan_idx];
    assign scan_stamp  = r_head_stamp[scan_idx];
    assign sorts_first = (scan_key < r_best_key) ||
                         ((scan_key == r_best_key) && (scan_stamp > r_best_stamp));
    assign take        = r_head_full[scan_idx] && (!r_found || sorts_first);
    assign best_idx    = r_best[IDX_W-1:0];
    assign dup         = r_last_set && (r_last_key == r_best_key);

    assign o_status.need_scan = run_match && (!was_priming || !prime_more);
    assign o_status.scan_last = {1'b0, r_scan} == (eff_runs - RUNS_W'(1));

    // Build the next result word
    always_comb begin
        n_strobe = 1'b0;
        n_result = '0;
        if (!i_cfg_we) begin
            if (i_cmd.accept) begin
                if (!run_match) begin
                    n_strobe            = 1'b1;
                    n_result.refill_run = r_awaited;
                    n_result.priming    = was_priming;
                    n_result.run_error  = 1'b1;
                end else if (was_priming && prime_more) begin
                    n_strobe            = 1'b1;
                    n_result.refill_run = primed_inc[RUN_W-1:0];
                    n_result.priming    = 1'b1;
                end
            end else if (i_cmd.finish) begin
                n_strobe = 1'b1;
                if (!r_found) begin
                    n_result.priming    = 1'b1;
                    n_result.merge_done = 1'b1;
                end else begin
                    n_result.refill_run = r_best;
                    if (!dup) begin
                        n_result.emit_valid = 1'b1;
                        n_result.out_key    = r_best_key;
                        n_result.out_stamp  = r_best_stamp;
                    end
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_runs      <= RUNS_RESET;
            r_head_full <= '0;
            r_primed    <= '0;
            r_awaited   <= '0;
            r_last_set  <= 1'b0;
            r_scan      <= '0;
            r_found     <= 1'b0;
            r_best      <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                // A new run count restarts the merge
                r_runs      <= i_cfg_data;
                r_head_full <= '0;
                r_primed    <= '0;
                r_awaited   <= '0;
                r_last_set  <= 1'b0;
            end else if (i_cmd.accept) begin
                r_scan  <= '0;
                r_found <= 1'b0;
                if (run_match) begin
                    if (aw_ok) begin
                        r_head_full[aw_idx] <= (i_item.operation == OP_NEXT);
                    end
                    if (was_priming) begin
                        r_primed <= primed_inc;
                        if (prime_more) begin
                            r_awaited <= primed_inc[RUN_W-1:0];
                        end
                    end
                end
            end else if (i_cmd.scan) begin
                r_scan <= r_scan + RUN_W'(1);
                if (take) begin
                    r_found <= 1'b1;
                    r_best  <= r_scan;
                end
            end else if (i_cmd.finish) begin
                if (!r_found) begin
                    // Every run exhausted: back to priming
                    r_head_full <= '0;
                    r_primed    <= '0;
                    r_awaited   <= '0;
                    r_last_set  <= 1'b0;
                end else begin
                    r_head_full[best_idx] <= 1'b0;
                    r_awaited             <= r_best;
                    if (!dup) begin
                        r_last_set <= 1'b1;
                    end
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !i_cfg_we) begin
            if (run_match && aw_ok && (i_item.operation == OP_NEXT)) begin
                r_head_key[aw_idx]   <= i_item.record_key;
                r_head_stamp[aw_idx] <= i_item.record_stamp;
            end
        end else if (i_cmd.scan && take) begin
            r_best_key   <= scan_key;
            r_best_stamp <= scan_stamp;
        end else if (i_cmd.finish && r_found && !dup) begin
            r_last_key <= r_best_key;
        end
        if (n_strobe) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

### hw/rtl/kway_merge_dedup.sv
// Top level of the k-way merge with duplicate-key removal.
// Depends on kmd_pkg, kmd_ctrl and kmd_datapath.
//
// Usage:
//   Input words (i_item) are taken at a clock edge with start high and busy
//   low. Each accepted word gives one result word on o_result, shown for one
//   cycle with o_strobe high; the receiver cannot stall it.
//   i_cfg_we/i_cfg_data write the run count (1..8); a write restarts the merge.
//   Latency and throughput:
//     priming words and words from the wrong run: result one cycle after
//     accept, the next word may be taken right then (1 cycle per word).
//     merge words: the single head comparator visits the heads of all runs
//     in use, one per cycle, then the finish state builds the result word,
//     which is registered as the block returns to idle; no word is taken
//     during the scan, and busy drops in the cycle the result is shown.
//   refill_run in each result names the run whose word is taken next.
//   Reset sets the run count to 8, clears all heads and starts priming at
//   run 0; no result is pending after reset.
module kway_merge_dedup
    import kmd_pkg::*;
#(
    parameter int NUM_RUNS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    input  logic              i_cfg_we,
    input  logic [RUNS_W-1:0] i_cfg_data,
    output logic              o_strobe,
    output t_result           o_result
);

    t_cmd    cmd;
    t_status status;

    kmd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    kmd_datapath #(
        .NUM_RUNS (NUM_RUNS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    // Results are shown only while the block is idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result word shown while busy");

    // End of a merge step always delivers its result
    a_finish_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_strobe)
        else $error("merge step ended without a result word");

    // An emitted record never coincides with priming, done or a run error
    a_emit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.emit_valid |->
            !o_result.priming && !o_result.merge_done && !o_result.run_error)
        else $error("emitted record with priming, done or error flag");

endmodule

### tb/sv/tb.sv
// Testbench for kway_merge_dedup: drives record words and run-count writes, predicts
// every result word with its own merge model and compares field by field.
// Depends on kmd_pkg and the kway_merge_dedup RTL.
module tb;
    import kmd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RECORD_TARGET  = 700;
    localparam int DRAIN_CYCLES   = 12;
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_item             i_item;
    logic              i_cfg_we;
    logic [RUNS_W-1:0] i_cfg_data;
    logic              o_strobe;
    t_result           o_result;

    // Merge model state
    logic [RUNS_W-1:0]        run_count;
    logic signed [KEY_W-1:0]  head_key_m [MAX_RUNS];
    logic [STAMP_W-1:0]       head_stamp_m [MAX_RUNS];
    logic                     head_valid_m [MAX_RUNS];
    int                       heads_primed;
    logic [RUN_W-1:0]         awaited;
    logic signed [KEY_W-1:0]  emitted_key;
    logic                     emitted_key_set;

    t_result merge_results_due[$];
    t_result latest_result;
    int      records_taken;
    int      mismatch_count = 0;
    int      quiet_cycles = 0;
    int      burst_left;

    kway_merge_dedup u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Return the model to an empty merge that primes run 0 next
    function automatic void clear_merge_heads();
        for (int i = 0; i < MAX_RUNS; i++) begin
            head_key_m[i]   = '0;
            head_stamp_m[i] = '0;
            head_valid_m[i] = 1'b0;
        end
        heads_primed    = 0;
        awaited         = '0;
        emitted_key     = '0;
        emitted_key_set = 1'b0;
    endfunction

    // Compute the result word caused by one accepted record word
    function automatic t_result next_merge_result(t_item w);
        t_result r;
        int      n;
        bit      was_priming;
        bit      found;
        int      best;
        r = '0;
        n = run_count;
        if (n < 1) n = 1;
        if (n > MAX_RUNS) n = MAX_RUNS;
        was_priming = heads_primed < n;

        // Flag and drop a word from a run other than the awaited one
        if (w.run_index != awaited) begin
            r.run_error  = 1'b1;
            r.refill_run = awaited;
            r.priming    = was_priming;
            return r;
        end

        if (w.operation == OP_NEXT) begin
            head_key_m[awaited]   = w.record_key;
            head_stamp_m[awaited] = w.record_stamp;
            head_valid_m[awaited] = 1'b1;
        end else begin
            head_valid_m[awaited] = 1'b0;
        end

        if (was_priming) begin
            heads_primed++;
            if (heads_primed < n) begin
                awaited      = heads_primed[RUN_W-1:0];
                r.refill_run = awaited;
                r.priming    = 1'b1;
                return r;
            end
        end

        // Pick the smallest head: key ascending, then newest stamp, lowest run on ties
        found = 1'b0;
        best  = 0;
        for (int i = 0; i < n; i++) begin
            if (head_valid_m[i] && (!found || head_key_m[i] < head_key_m[best] ||
                (head_key_m[i] == head_key_m[best] && head_stamp_m[i] > head_stamp_m[best])))
            begin
                best  = i;
                found = 1'b1;
            end
        end

        if (!found) begin
            clear_merge_heads();
            r.priming    = 1'b1;
            r.merge_done = 1'b1;
            return r;
        end

        head_valid_m[best] = 1'b0;
        awaited            = best[RUN_W-1:0];
        r.refill_run       = awaited;
        // Drop a repeat of the last emitted key
        if (emitted_key_set && emitted_key == head_key_m[best])
            return r;
        emitted_key     = head_key_m[best];
        emitted_key_set = 1'b1;
        r.emit_valid    = 1'b1;
        r.out_key       = head_key_m[best];
        r.out_stamp     = head_stamp_m[best];
        return r;
    endfunction

    function automatic t_item make_word(logic op, logic [RUN_W-1:0] run,
                                        logic signed [KEY_W-1:0] key,
                                        logic [STAMP_W-1:0] stamp);
        t_item w;
        w.operation    = op;
        w.run_index    = run;
        w.record_key   = key;
        w.record_stamp = stamp;
        return w;
    endfunction

    // Offer one word and hold it until the block takes it
    task automatic send_word(input t_item w);
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        latest_result = next_merge_result(w);
        merge_results_due.push_back(latest_result);
        if (!latest_result.run_error)
            records_taken++;
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Pause the sender until every expected word has come back
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (merge_results_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_run_count(input logic [RUNS_W-1:0] value);
        @(negedge i_clk);
        start      <= 1'b0;
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        run_count = value;
        clear_merge_heads();
    endtask

    // Insert sender gaps between bursts of random length
    task automatic pace_sender();
        if (burst_left == 0) begin
            hold_off($urandom_range(1, 6));
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 15) == 0)
                drain_results();
        end
        burst_left--;
    endtask

    // Feed one merge from sorted runs with random content; stop at done or after cut words
    task automatic run_merge(input int max_len, input int cut);
        int                      left [MAX_RUNS];
        logic signed [KEY_W-1:0] key_now [MAX_RUNS];
        logic [STAMP_W-1:0]      stamp_now [MAX_RUNS];
        logic signed [KEY_W-1:0] base;
        t_item                   w;
        int                      sent;
        int                      r;
        int                      step;
        base = {$urandom, $urandom};
        for (int i = 0; i < MAX_RUNS; i++) begin
            left[i]      = $urandom_range(0, max_len);
            key_now[i]   = base + $urandom_range(0, 6);
            stamp_now[i] = $urandom;
        end
        sent = 0;
        do begin
            pace_sender();
            r = awaited;
            w = make_word(OP_NEXT, awaited, {$urandom, $urandom}, $urandom);
            if ($urandom_range(0, 15) == 0) begin
                // noise from a run that is not awaited
                w.operation = 1'($urandom_range(0, 1));
                w.run_index = awaited + RUN_W'($urandom_range(1, 7));
            end else if (left[r] == 0 || $urandom_range(0, 29) == 0) begin
                w.operation = OP_EXHAUST;
                left[r]     = 0;
            end else begin
                step = $urandom_range(0, 2);
                if (step == 0)
                    stamp_now[r] = $urandom_range(stamp_now[r], 0);
                else
                    stamp_now[r] = $urandom;
                key_now[r]     = key_now[r] + step;
                w.record_key   = key_now[r];
                w.record_stamp = stamp_now[r];
                left[r]--;
            end
            send_word(w);
            sent++;
        end while (!latest_result.merge_done && sent != cut);
    endtask

    // Exhaust whatever run is awaited until the merge reports done
    task automatic finish_merge();
        do send_word(make_word(OP_EXHAUST, awaited, '0, '0));
        while (!latest_result.merge_done);
    endtask

    // Priming with extreme records, an empty run, a stray run, equal heads and repeats
    task automatic test_priming_extremes();
        send_word(make_word(OP_NEXT, 3'd0, KEY_MIN, '1));
        send_word(make_word(OP_NEXT, 3'd1, KEY_MAX, '0));
        send_word(make_word(OP_EXHAUST, 3'd2, KEY_MAX, '1));
        send_word(make_word(OP_NEXT, 3'd5, 64'sd12, 32'd12));
        send_word(make_word(OP_NEXT, 3'd3, -64'sd1, 32'd5));
        send_word(make_word(OP_NEXT, 3'd4, -64'sd1, 32'd9));
        send_word(make_word(OP_NEXT, 3'd5, 64'sd0, 32'd1));
        send_word(make_word(OP_NEXT, 3'd6, 64'sd0, 32'd1));
        send_word(make_word(OP_NEXT, 3'd7, 64'sd7, 32'd3));
        send_word(make_word(OP_NEXT, 3'd0, KEY_MIN, 32'h7FFF_FFFF));
        send_word(make_word(OP_NEXT, 3'd7, KEY_MIN, '1));
        finish_merge();
    endtask

    // Run-count writes at the extremes and out of range, each with a short merge
    task automatic test_run_count();
        logic [RUNS_W-1:0] counts [5];
        counts = '{4'd0, 4'd1, 4'd15, 4'd2, RUNS_RESET};
        foreach (counts[i]) begin
            drain_results();
            write_run_count(counts[i]);
            run_merge(3, 0);
        end
    endtask

    // Random merges, with restarts and run-count changes between them
    task automatic test_random_merges();
        int cut;
        while (records_taken < RECORD_TARGET) begin
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
            run_merge($urandom_range(0, 10), cut);
            if (cut != 0 || $urandom_range(0, 2) == 0) begin
                drain_results();
                if ($urandom_range(0, 4) == 0)
                    write_run_count(RUNS_W'($urandom_range(0, 15)));
                else
                    write_run_count(RUNS_W'($urandom_range(1, MAX_RUNS)));
            end
        end
    endtask

    task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result word with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (merge_results_due.size() == 0) begin
                $error("result word with none expected");
                mismatch_count++;
            end else begin
                want = merge_results_due.pop_front();
                check_field("emit_valid", want.emit_valid, o_result.emit_valid);
                check_field("out_key", want.out_key, o_result.out_key);
                check_field("out_stamp", want.out_stamp, o_result.out_stamp);
                check_field("refill_run", want.refill_run, o_result.refill_run);
                check_field("priming", want.priming, o_result.priming);
                check_field("merge_done", want.merge_done, o_result.merge_done);
                check_field("run_error", want.run_error, o_result.run_error);
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_item         = '0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        records_taken  = 0;
        burst_left     = 0;
        run_count      = RUNS_RESET;
        clear_merge_heads();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_priming_extremes();
        test_run_count();
        test_random_merges();

        drain_results();
        hold_off(DRAIN_CYCLES);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
